// File: rtl/core/sleep_state_package_scan_unit_defines.svh
// assertion macros shared by the sleep state package scan rtl
`ifndef SLEEP_STATE_PACKAGE_SCAN_UNIT_DEFINES_SVH
`define SLEEP_STATE_PACKAGE_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define SSPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssps check failed");

// next-cycle implication, quiet while in reset
`define SSPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssps check failed");

`endif

// File: rtl/core/ssps_pkg.sv
// types and constants for the sleep state package scanner
`timescale 1ns / 1ps
`default_nettype none

package ssps_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] scan_status;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD       = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_LEAD    = 4'd1,
    PH_SKIP    = 4'd2,
    PH_COUNT   = 4'd3,
    PH_A_PRE   = 4'd4,
    PH_A_OPD   = 4'd5,
    PH_A_REST  = 4'd6,
    PH_B_PRE   = 4'd7,
    PH_B_OPD   = 4'd8,
    PH_B_REST  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [55:0] window;
    logic [2:0]  fill;
    phase_t      phase;
    logic [2:0]  hdr_span;
    logic [1:0]  skip;
    logic [7:0]  elem;
    logic [7:0]  first;
    logic        verdict;
  } scan_state_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  localparam scan_state_t SCAN_RESET = '{
    window:   56'd0,
    fill:     3'd0,
    phase:    PH_SEARCH,
    hdr_span: 3'd0,
    skip:     2'd0,
    elem:     8'd0,
    first:    8'd0,
    verdict:  1'b0
  };

  localparam logic [55:0] HDR_LONG  = 56'h085C5F53355F12;
  localparam logic [47:0] HDR_SHORT = 48'h085F53355F12;
  localparam logic [7:0]  PFX_ZERO  = 8'h00;
  localparam logic [7:0]  PFX_ONE   = 8'h01;
  localparam logic [7:0]  PFX_BYTE  = 8'h0A;
  localparam logic [7:0]  PFX_WORD  = 8'h0B;
  localparam logic [7:0]  PFX_DWORD = 8'h0C;
  localparam logic [7:0]  TYPE_MAX  = 8'd7;
  localparam logic [2:0]  FILL_FULL = 3'd7;
  localparam logic [2:0]  FILL_SHORT = 3'd6;
  localparam logic [2:0]  DIST_MAX  = 3'd7;

endpackage

`default_nettype wire

// File: rtl/core/ssps_step.sv
// next-state and result logic for one table byte
`timescale 1ns / 1ps
`default_nettype none

module ssps_step (
  input  ssps_pkg::scan_state_t st_r,
  input  ssps_pkg::in_item_t    in_item,
  output ssps_pkg::scan_state_t st_nxt,
  output ssps_pkg::step_res_t   res
);
  import ssps_pkg::*;

  logic       is_b;
  logic       fin;
  logic [7:0] fin_val;
  logic       do_judge;
  logic [7:0] jdg_a;
  logic [7:0] jdg_b;
  logic       verdict_now;
  status_t    code;
  logic [1:0] skip_dec;
  phase_t     opd_phase;
  phase_t     rest_phase;

  always_comb begin
    st_nxt      = st_r;
    res         = '0;
    is_b        = 1'b0;
    fin         = 1'b0;
    fin_val     = 8'd0;
    do_judge    = 1'b0;
    jdg_a       = 8'd0;
    jdg_b       = 8'd0;
    verdict_now = 1'b0;
    code        = ST_OK;
    skip_dec    = st_r.skip;
    opd_phase   = PH_A_OPD;
    rest_phase  = PH_A_REST;

    st_nxt.window = {st_r.window[47:0], in_item.data_byte};
    if (st_r.fill != FILL_FULL) begin
      st_nxt.fill = st_r.fill + 3'd1;
    end

    if (!st_r.verdict) begin
      if (st_r.phase != PH_SEARCH && st_r.hdr_span != DIST_MAX) begin
        st_nxt.hdr_span = st_r.hdr_span + 3'd1;
      end
      case (st_r.phase)
        PH_SEARCH: begin
          if (st_nxt.fill == FILL_FULL && st_nxt.window == HDR_LONG) begin
            st_nxt.phase    = PH_LEAD;
            st_nxt.hdr_span = 3'd6;
          end else if (st_nxt.fill >= FILL_SHORT && st_nxt.window[47:0] == HDR_SHORT) begin
            st_nxt.phase    = PH_LEAD;
            st_nxt.hdr_span = 3'd5;
          end
        end
        PH_LEAD: begin
          st_nxt.skip  = in_item.data_byte[7:6];
          st_nxt.phase = (in_item.data_byte[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
        end
        PH_SKIP: begin
          if (st_r.skip != 2'd0) begin
            skip_dec = st_r.skip - 2'd1;
          end
          st_nxt.skip = skip_dec;
          if (skip_dec == 2'd0) begin
            st_nxt.phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          st_nxt.elem = in_item.data_byte;
          if (in_item.data_byte == 8'd0) begin
            verdict_now = 1'b1;
            code        = ST_BAD;
          end else begin
            st_nxt.phase = PH_A_PRE;
          end
        end
        PH_A_PRE, PH_B_PRE: begin
          is_b      = (st_r.phase == PH_B_PRE);
          opd_phase = is_b ? PH_B_OPD : PH_A_OPD;
          if (in_item.data_byte == PFX_ZERO || in_item.data_byte == PFX_ONE) begin
            fin     = 1'b1;
            fin_val = in_item.data_byte;
          end else if (in_item.data_byte == PFX_BYTE) begin
            st_nxt.skip  = 2'd0;
            st_nxt.phase = opd_phase;
          end else if (in_item.data_byte == PFX_WORD) begin
            st_nxt.skip  = 2'd1;
            st_nxt.phase = opd_phase;
          end else if (in_item.data_byte == PFX_DWORD) begin
            st_nxt.skip  = 2'd3;
            st_nxt.phase = opd_phase;
          end else begin
            verdict_now = 1'b1;
            code        = ST_BAD;
          end
        end
        PH_A_OPD, PH_B_OPD: begin
          is_b       = (st_r.phase == PH_B_OPD);
          rest_phase = is_b ? PH_B_REST : PH_A_REST;
          if (is_b) begin
            st_nxt.elem = in_item.data_byte;
          end else begin
            st_nxt.first = in_item.data_byte;
          end
          if (st_r.skip == 2'd0) begin
            fin     = 1'b1;
            fin_val = in_item.data_byte;
          end else begin
            st_nxt.phase = rest_phase;
          end
        end
        PH_A_REST, PH_B_REST: begin
          is_b = (st_r.phase == PH_B_REST);
          if (st_r.skip != 2'd0) begin
            skip_dec = st_r.skip - 2'd1;
          end
          st_nxt.skip = skip_dec;
          if (skip_dec == 2'd0) begin
            fin     = 1'b1;
            fin_val = is_b ? st_r.elem : st_r.first;
          end
        end
        default: begin
          st_nxt.phase = PH_SEARCH;
        end
      endcase

      // integer complete: either move on to the second one or judge what has been read
      if (fin) begin
        if (!is_b) begin
          st_nxt.first = fin_val;
          if (st_r.elem > 8'd1) begin
            st_nxt.phase = PH_B_PRE;
          end else begin
            do_judge = 1'b1;
            jdg_a    = fin_val;
            jdg_b    = 8'd0;
          end
        end else begin
          st_nxt.elem = fin_val;
          do_judge    = 1'b1;
          jdg_a       = st_r.first;
          jdg_b       = fin_val;
        end
      end

      if (do_judge) begin
        verdict_now = 1'b1;
        code        = (jdg_a > TYPE_MAX || jdg_b > TYPE_MAX) ? ST_BAD : ST_OK;
      end

      if (verdict_now) begin
        st_nxt.verdict       = 1'b1;
        res.valid            = 1'b1;
        res.item.scan_status = code;
        if (code == ST_OK) begin
          res.item.sleep_type_a = jdg_a[2:0];
          res.item.sleep_type_b = jdg_b[2:0];
        end
      end
    end

    // table end: report if still undecided, then start over
    if (in_item.last_byte) begin
      if (!st_nxt.verdict) begin
        res.valid = 1'b1;
        res.item.sleep_type_a = 3'd0;
        res.item.sleep_type_b = 3'd0;
        if (st_nxt.phase == PH_SEARCH || st_nxt.hdr_span != DIST_MAX) begin
          res.item.scan_status = ST_NOT_FOUND;
        end else begin
          res.item.scan_status = ST_BAD;
        end
      end
      st_nxt = SCAN_RESET;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sleep_state_package_scan_unit.sv
// top level of the sleep state package scanner
//
//   channel | ports                          | moves
//   --------+--------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data    | one table byte plus end marker
//   result  | out_valid, out_stall, out_data | one status per table
//
// a byte is taken each cycle in_stall is low; any result is registered onto out_*
// the step logic is a window compare plus a small phase update, combinational
// synchronous active-low reset returns the scan to header search
// results sit in an output register backed by a skid register
// in_stall rises only when both hold a result that has not been taken
`timescale 1ns / 1ps
`default_nettype none
`include "sleep_state_package_scan_unit_defines.svh"

module sleep_state_package_scan_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssps_pkg::out_item_t out_data
);
  import ssps_pkg::*;

  scan_state_t state_r;
  scan_state_t state_nxt;
  scan_state_t step_nxt;
  step_res_t   step_res;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_item_t skid_item_r;
  out_item_t skid_item_nxt;

  logic in_accept;
  logic out_take;
  logic new_res;

  ssps_step u_step (
    .st_r    (state_r),
    .in_item (in_data),
    .st_nxt  (step_nxt),
    .res     (step_res)
  );

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign new_res   = in_accept && step_res.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    state_nxt = in_accept ? step_nxt : state_r;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = step_res.item;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_item_nxt  = step_res.item;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SCAN_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  `SSPS_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r)
  `SSPS_ASSERT_NOW(a_undecided_end_reports, in_accept && in_data.last_byte && !state_r.verdict, step_res.valid)
  `SSPS_ASSERT_NOW(a_no_second_verdict, in_accept && state_r.verdict, !step_res.valid)
  `SSPS_ASSERT_NEXT(a_end_restarts, in_accept && in_data.last_byte, state_r.phase == PH_SEARCH && state_r.fill == 3'd0)

endmodule

`default_nettype wire
